/* rtl/core/fufr_pkg.sv */
// Shared types and constants of the firmware update frame receiver.
`default_nettype none

package fufr_pkg;

    // Sizes of the flash layout and of the frame buffer
    localparam int unsigned SECTOR_BYTES = 4096;
    localparam int unsigned MAX_PAYLOAD  = 64;
    localparam int unsigned WORD_BYTES   = 8;

    localparam int unsigned SECTOR_AW = $clog2(SECTOR_BYTES);
    localparam int unsigned STORE_AW  = $clog2(MAX_PAYLOAD);
    localparam int unsigned DONE_W    = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned CNT_W     = $clog2(WORD_BYTES + 1);
    localparam int unsigned LANE_W    = $clog2(WORD_BYTES);
    localparam int unsigned POS_W     = 9;
    localparam int unsigned LEN_W     = 8;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned DATA_W    = 8 * WORD_BYTES;

    // Frame bytes
    localparam logic [7:0] BYTE_DATA_SOF  = 8'h03;
    localparam logic [7:0] BYTE_DATA_EOF  = 8'h04;
    localparam logic [7:0] BYTE_BEGIN_SOF = 8'h05;
    localparam logic [7:0] BYTE_BEGIN_EOF = 8'h06;

    // Reply codes
    localparam logic [7:0] REPLY_ACK    = 8'h01;
    localparam logic [7:0] REPLY_ERROR  = 8'h02;
    localparam logic [7:0] REPLY_FINISH = 8'h07;

    // Result kinds carried on tuser
    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_ERASE = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Output tdata layout, lowest bit up
    localparam int unsigned TD_REPLY_LSB = 0;
    localparam int unsigned TD_ADDR_LSB  = 8;
    localparam int unsigned TD_DATA_LSB  = TD_ADDR_LSB + ADDR_W;
    localparam int unsigned TD_CNT_LSB   = TD_DATA_LSB + DATA_W;
    localparam int unsigned TD_USED_W    = TD_CNT_LSB + CNT_W;
    localparam int unsigned TDATA_W      = ((TD_USED_W + 7) / 8) * 8;

    // Command from the sequencer to the word assembler
    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [7:0]          wr_data;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
        logic [LANE_W-1:0]   rd_lane;
        logic                clr;
    } asm_cmd_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        reply;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/core/firmware_update_frame_receiver.sv */
// Top level of the firmware update frame receiver.
`default_nettype none

// Takes one received byte per transaction and deframes begin frames (0x05, size high,
// size low, end byte) and data frames (0x03, length, payload, end byte). The end byte
// of a valid data frame runs a small sequencer around one shared 32-bit adder and the
// payload buffer, which gives out one byte per cycle, and emits write words of up to 8
// bytes each. The block takes no byte while that sequence runs. Results carry the kind
// on tuser and the final result caused by a byte on tlast. The user must write the base
// address only while the block is idle; the block itself does not enforce it.
module firmware_update_frame_receiver (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [31:0]                    cfg_wr_data,   // update_base_address
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // rx_byte
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // reply_byte, flash_address, write_data, write_byte_count, zero pad
    output logic [fufr_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,  // result_kind
    output logic                                m_axis_tlast   // last_of_run
);

    typedef enum logic [9:0] {
        S_RX     = 10'b00_0000_0001,
        S_ADDR   = 10'b00_0000_0010,
        S_ERASE  = 10'b00_0000_0100,
        S_WLOAD  = 10'b00_0000_1000,
        S_WDRAIN = 10'b00_0001_0000,
        S_WEMIT  = 10'b00_0010_0000,
        S_OFFSET = 10'b00_0100_0000,
        S_ACK    = 10'b00_1000_0000,
        S_FIN    = 10'b01_0000_0000,
        S_REPLY  = 10'b10_0000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_BEGIN = 3'b010,
        PH_DATA  = 3'b100
    } phase_t;

    state_t                             state_reg, state_next;
    phase_t                             phase_reg, phase_next;
    logic [fufr_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [fufr_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [fufr_pkg::DONE_W-1:0]        count_reg, count_next;
    logic [15:0]                        size_reg, size_next;
    logic [fufr_pkg::ADDR_W-1:0]        offset_reg, offset_next;
    logic [fufr_pkg::ADDR_W-1:0]        base_reg, base_next;
    logic [fufr_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic [fufr_pkg::DONE_W-1:0]        done_reg, done_next;
    logic [fufr_pkg::LANE_W-1:0]        k_reg, k_next;
    logic [7:0]                         reply_reg, reply_next;
    logic                               out_valid_reg, out_valid_next;
    fufr_pkg::result_t                  out_reg, out_next;

    logic [fufr_pkg::ADDR_W-1:0]        add_a, add_b, add_sum;
    logic [fufr_pkg::DONE_W-1:0]        rem;
    logic [fufr_pkg::CNT_W-1:0]         cnt;
    logic [fufr_pkg::DONE_W-1:0]        done_sum;
    logic [fufr_pkg::DONE_W-1:0]        rd_idx;
    logic                               in_xact;
    logic                               out_free;
    logic                               emit;
    fufr_pkg::result_t                  res;
    fufr_pkg::asm_cmd_t                 cmd;
    logic [fufr_pkg::DATA_W-1:0]        word;

    fufr_word_asm u_word_asm (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .word  (word)
    );

    assign in_xact  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign add_sum  = add_a + add_b;

    // Bytes left in the frame and size of the current write word
    assign rem      = fufr_pkg::DONE_W'(len_reg) - done_reg;
    assign cnt      = (rem > fufr_pkg::DONE_W'(fufr_pkg::WORD_BYTES)) ?
                      fufr_pkg::CNT_W'(fufr_pkg::WORD_BYTES) : rem[fufr_pkg::CNT_W-1:0];
    assign done_sum = done_reg + fufr_pkg::DONE_W'(cnt);
    assign rd_idx   = done_reg + fufr_pkg::DONE_W'(k_reg);

    // Shared adder operand select
    always_comb
    begin
        case (state_reg)
            S_WEMIT:
            begin
                add_a = addr_reg;
                add_b = fufr_pkg::ADDR_W'(done_reg);
            end
            S_OFFSET:
            begin
                add_a = offset_reg;
                add_b = fufr_pkg::ADDR_W'(len_reg);
            end
            default:
            begin
                add_a = base_reg;
                add_b = offset_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        size_next   = size_reg;
        offset_next = offset_reg;
        base_next   = base_reg;
        addr_next   = addr_reg;
        done_next   = done_reg;
        k_next      = k_reg;
        reply_next  = reply_reg;
        emit        = 1'b0;
        res         = '0;
        cmd         = '0;
        cmd.wr_addr = count_reg[fufr_pkg::STORE_AW-1:0];
        cmd.wr_data = s_axis_tdata;
        cmd.rd_addr = rd_idx[fufr_pkg::STORE_AW-1:0];
        cmd.rd_lane = k_reg;

        if (cfg_wr_en)
        begin
            base_next = cfg_wr_data;
        end

        case (state_reg)
            S_RX:
            begin
                if (in_xact)
                begin
                    case (phase_reg)
                        PH_BEGIN:
                        begin
                            if (pos_reg == fufr_pkg::POS_W'(1))
                            begin
                                size_next = {s_axis_tdata, 8'h00};
                                pos_next  = fufr_pkg::POS_W'(2);
                            end
                            else if (pos_reg == fufr_pkg::POS_W'(2))
                            begin
                                size_next = {size_reg[15:8], s_axis_tdata};
                                pos_next  = fufr_pkg::POS_W'(3);
                            end
                            else
                            begin
                                if (s_axis_tdata == fufr_pkg::BYTE_BEGIN_EOF)
                                begin
                                    reply_next = fufr_pkg::REPLY_ACK;
                                end
                                else
                                begin
                                    size_next  = '0;
                                    reply_next = fufr_pkg::REPLY_ERROR;
                                end
                                phase_next = PH_IDLE;
                                pos_next   = '0;
                                state_next = S_REPLY;
                            end
                        end
                        PH_DATA:
                        begin
                            if (pos_reg == fufr_pkg::POS_W'(1))
                            begin
                                len_next   = s_axis_tdata;
                                count_next = '0;
                                pos_next   = fufr_pkg::POS_W'(2);
                            end
                            else if (pos_reg < (fufr_pkg::POS_W'(len_reg) + fufr_pkg::POS_W'(2)))
                            begin
                                // Keep the first MAX_PAYLOAD bytes, drop the rest
                                if (count_reg < fufr_pkg::DONE_W'(fufr_pkg::MAX_PAYLOAD))
                                begin
                                    cmd.wr_en  = 1'b1;
                                    count_next = count_reg + fufr_pkg::DONE_W'(1);
                                end
                                pos_next = pos_reg + fufr_pkg::POS_W'(1);
                            end
                            else
                            begin
                                if ((s_axis_tdata == fufr_pkg::BYTE_DATA_EOF) &&
                                    (len_reg <= fufr_pkg::LEN_W'(fufr_pkg::MAX_PAYLOAD)))
                                begin
                                    state_next = S_ADDR;
                                end
                                else
                                begin
                                    reply_next = fufr_pkg::REPLY_ERROR;
                                    state_next = S_REPLY;
                                end
                                phase_next = PH_IDLE;
                                pos_next   = '0;
                                count_next = '0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                            if (s_axis_tdata == fufr_pkg::BYTE_DATA_SOF)
                            begin
                                phase_next = PH_DATA;
                                pos_next   = fufr_pkg::POS_W'(1);
                            end
                            else if (s_axis_tdata == fufr_pkg::BYTE_BEGIN_SOF)
                            begin
                                phase_next = PH_BEGIN;
                                pos_next   = fufr_pkg::POS_W'(1);
                            end
                        end
                    endcase
                end
            end
            S_ADDR:
            begin
                addr_next  = add_sum;
                done_next  = '0;
                k_next     = '0;
                state_next = S_ERASE;
            end
            S_ERASE:
            begin
                if (addr_reg[fufr_pkg::SECTOR_AW-1:0] != '0)
                begin
                    state_next = (len_reg == '0) ? S_OFFSET : S_WLOAD;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    res.kind   = fufr_pkg::KIND_ERASE;
                    res.addr   = addr_reg;
                    state_next = (len_reg == '0) ? S_OFFSET : S_WLOAD;
                end
            end
            S_WLOAD:
            begin
                cmd.rd_en = 1'b1;
                cmd.clr   = (k_reg == '0);
                if ((fufr_pkg::CNT_W'(k_reg) + fufr_pkg::CNT_W'(1)) == cnt)
                begin
                    k_next     = '0;
                    state_next = S_WDRAIN;
                end
                else
                begin
                    k_next = k_reg + fufr_pkg::LANE_W'(1);
                end
            end
            S_WDRAIN:
            begin
                state_next = S_WEMIT;
            end
            S_WEMIT:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    res.kind  = fufr_pkg::KIND_WRITE;
                    res.addr  = add_sum;
                    res.data  = word;
                    res.count = cnt;
                    done_next = done_sum;
                    state_next = (fufr_pkg::LEN_W'(done_sum) >= len_reg) ? S_OFFSET : S_WLOAD;
                end
            end
            S_OFFSET:
            begin
                offset_next = add_sum;
                state_next  = S_ACK;
            end
            S_ACK:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    res.reply = fufr_pkg::REPLY_ACK;
                    if (offset_reg == fufr_pkg::ADDR_W'(size_reg))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        res.last   = 1'b1;
                        state_next = S_RX;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res.reply  = fufr_pkg::REPLY_FINISH;
                    res.last   = 1'b1;
                    state_next = S_RX;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    res.reply  = reply_reg;
                    res.last   = 1'b1;
                    state_next = S_RX;
                end
            end
            default:
            begin
                state_next = S_RX;
            end
        endcase
    end

    // Output register: load on a new result, otherwise drop after the transaction
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RX;
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            size_reg      <= '0;
            offset_reg    <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            size_reg      <= size_next;
            offset_reg    <= offset_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        done_reg  <= done_next;
        k_reg     <= k_next;
        reply_reg <= reply_next;
        out_reg   <= out_next;
    end

    assign s_axis_tready = (state_reg == S_RX);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {{(fufr_pkg::TDATA_W - fufr_pkg::TD_USED_W){1'b0}},
                            out_reg.count, out_reg.data, out_reg.addr, out_reg.reply};

endmodule

`default_nettype wire

/* rtl/core/fufr_word_asm.sv */
// Payload buffer and little-endian assembly of flash write words.
`default_nettype none

module fufr_word_asm (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fufr_pkg::asm_cmd_t              cmd,
    output logic [fufr_pkg::DATA_W-1:0]          word
);

    logic [7:0]                      store_mem [fufr_pkg::MAX_PAYLOAD];
    logic [7:0]                      rd_byte_reg;
    logic [fufr_pkg::LANE_W-1:0]     lane_reg;
    logic                            fill_reg;
    logic [fufr_pkg::DATA_W-1:0]     word_reg;
    logic [fufr_pkg::DATA_W-1:0]     word_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_byte_reg <= store_mem[cmd.rd_addr];
        end
        lane_reg <= cmd.rd_lane;
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= cmd.rd_en;
        end
    end

    // Clear on the first read of a word; drop each byte into its lane from the registered read byte
    always_comb
    begin
        word_next = word_reg;
        if (cmd.clr)
        begin
            word_next = '0;
        end
        for (int i = 0; i < fufr_pkg::WORD_BYTES; i++)
        begin
            if (fill_reg && (lane_reg == fufr_pkg::LANE_W'(i)))
            begin
                word_next[8*i +: 8] = rd_byte_reg;
            end
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

/* rtl/core/fufr_checker.sv */
// Port-level checks of the firmware update frame receiver, bound to the top level.
`default_nettype none

module fufr_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [fufr_pkg::TDATA_W-1:0]   m_axis_tdata,
    input  wire logic [1:0]                     m_axis_tuser,
    input  wire logic                           m_axis_tlast
);

    // A stalled result transaction holds its contents
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
             $stable(m_axis_tlast));
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // No byte is taken while a run of results is still unfinished
    property p_run_blocks_input;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready;
    endproperty
    a_run_blocks_input: assert property (p_run_blocks_input)
        else $error("input taken during a result run");

    // Erase and write requests are never marked last, since a reply always follows them
    property p_flash_not_last;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser == fufr_pkg::KIND_ERASE) ||
                           (m_axis_tuser == fufr_pkg::KIND_WRITE))) |-> !m_axis_tlast;
    endproperty
    a_flash_not_last: assert property (p_flash_not_last)
        else $error("flash request marked last");

    // A write word carries one to eight bytes and no reply code
    property p_write_count;
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == fufr_pkg::KIND_WRITE)) |->
            ((m_axis_tdata[fufr_pkg::TD_CNT_LSB +: fufr_pkg::CNT_W] != '0) &&
             (m_axis_tdata[fufr_pkg::TD_CNT_LSB +: fufr_pkg::CNT_W] <=
              fufr_pkg::CNT_W'(fufr_pkg::WORD_BYTES)) &&
             (m_axis_tdata[7:0] == 8'h00));
    endproperty
    a_write_count: assert property (p_write_count)
        else $error("bad write word byte count");

endmodule

bind firmware_update_frame_receiver fufr_checker u_fufr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/firmware_update_frame_receiver_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench: streams framed bytes into the frame receiver and checks every result.

module firmware_update_frame_receiver_tb;

    localparam int unsigned RANDOM_BYTES = 400;
    localparam int unsigned IDLE_GUARD   = 100;
    localparam int unsigned TIMEOUT_NS   = 1_000_000;

    typedef enum logic [1:0] {
        FR_IDLE  = 2'd0,
        FR_BEGIN = 2'd1,
        FR_DATA  = 2'd2
    } frame_state_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS   = 2'd0,
        RDY_HALF     = 2'd1,
        RDY_SPARSE   = 2'd2,
        RDY_PERIODIC = 2'd3
    } ready_mode_t;

    class deframer_scoreboard;
        frame_state_t      frame_state;
        logic [8:0]        frame_pos;
        logic [7:0]        frame_len;
        logic [6:0]        kept_count;
        logic [15:0]       announced_size;
        logic [31:0]       image_offset;
        logic [31:0]       base_addr;
        logic [7:0]        payload [fufr_pkg::MAX_PAYLOAD];
        fufr_pkg::result_t byte_results [$];
        fufr_pkg::result_t expected_results [$];
        int unsigned       errors;

        function new();
            frame_state    = FR_IDLE;
            frame_pos      = '0;
            frame_len      = '0;
            kept_count     = '0;
            announced_size = '0;
            image_offset   = '0;
            base_addr      = '0;
            errors         = 0;
        endfunction

        function void set_base(logic [31:0] value);
            base_addr = value;
        endfunction

        function int unsigned pending_count();
            return expected_results.size();
        endfunction

        function void add_result(logic [1:0] kind, logic [7:0] reply, logic [31:0] addr,
                                 logic [fufr_pkg::DATA_W-1:0] data,
                                 logic [fufr_pkg::CNT_W-1:0] count);
            fufr_pkg::result_t r;
            r.kind  = kind;
            r.reply = reply;
            r.addr  = addr;
            r.data  = data;
            r.count = count;
            r.last  = 1'b0;
            byte_results.push_back(r);
        endfunction

        // End byte of a data frame: erase at a sector start, write words, then the replies; else an error reply
        function void close_data_frame(logic [7:0] end_byte);
            logic [31:0]                 addr;
            int unsigned                 done;
            int unsigned                 cnt;
            logic [fufr_pkg::DATA_W-1:0] word;
            if (end_byte == fufr_pkg::BYTE_DATA_EOF &&
                32'(frame_len) <= fufr_pkg::MAX_PAYLOAD)
            begin
                addr = base_addr + image_offset;
                if (addr % fufr_pkg::SECTOR_BYTES == 0)
                begin
                    add_result(fufr_pkg::KIND_ERASE, 8'h00, addr, '0, '0);
                end
                done = 0;
                while (done < 32'(frame_len))
                begin
                    cnt  = (32'(frame_len) - done > fufr_pkg::WORD_BYTES) ?
                           fufr_pkg::WORD_BYTES : 32'(frame_len) - done;
                    word = '0;
                    for (int i = 0; i < cnt; i++)
                    begin
                        word[8*i +: 8] = payload[(done + i) % fufr_pkg::MAX_PAYLOAD];
                    end
                    add_result(fufr_pkg::KIND_WRITE, 8'h00, addr + done, word,
                               cnt[fufr_pkg::CNT_W-1:0]);
                    done += cnt;
                end
                image_offset = image_offset + 32'(frame_len);
                add_result(fufr_pkg::KIND_REPLY, fufr_pkg::REPLY_ACK, '0, '0, '0);
                if (image_offset == {16'h0000, announced_size})
                begin
                    add_result(fufr_pkg::KIND_REPLY, fufr_pkg::REPLY_FINISH, '0, '0, '0);
                end
            end
            else
            begin
                add_result(fufr_pkg::KIND_REPLY, fufr_pkg::REPLY_ERROR, '0, '0, '0);
            end
        endfunction

        function void note_rx_byte(logic [7:0] b);
            fufr_pkg::result_t tail;
            byte_results.delete();
            case (frame_state)
                FR_BEGIN:
                begin
                    if (frame_pos == 9'd1)
                    begin
                        announced_size = {b, 8'h00};
                        frame_pos      = 9'd2;
                    end
                    else if (frame_pos == 9'd2)
                    begin
                        announced_size[7:0] = b;
                        frame_pos           = 9'd3;
                    end
                    else
                    begin
                        if (b == fufr_pkg::BYTE_BEGIN_EOF)
                        begin
                            add_result(fufr_pkg::KIND_REPLY, fufr_pkg::REPLY_ACK,
                                       '0, '0, '0);
                        end
                        else
                        begin
                            announced_size = '0;
                            add_result(fufr_pkg::KIND_REPLY, fufr_pkg::REPLY_ERROR,
                                       '0, '0, '0);
                        end
                        frame_state = FR_IDLE;
                        frame_pos   = '0;
                    end
                end
                FR_DATA:
                begin
                    if (frame_pos == 9'd1)
                    begin
                        frame_len  = b;
                        kept_count = '0;
                        frame_pos  = 9'd2;
                    end
                    else if (int'(frame_pos) < int'(frame_len) + 2)
                    begin
                        // drop payload bytes past the buffer, but keep counting
                        if (32'(kept_count) < fufr_pkg::MAX_PAYLOAD)
                        begin
                            payload[kept_count[5:0]] = b;
                            kept_count++;
                        end
                        frame_pos = frame_pos + 9'd1;
                    end
                    else
                    begin
                        close_data_frame(b);
                        frame_state = FR_IDLE;
                        frame_pos   = '0;
                        kept_count  = '0;
                    end
                end
                default:
                begin
                    frame_state = FR_IDLE;
                    if (b == fufr_pkg::BYTE_DATA_SOF)
                    begin
                        frame_state = FR_DATA;
                        frame_pos   = 9'd1;
                    end
                    else if (b == fufr_pkg::BYTE_BEGIN_SOF)
                    begin
                        frame_state = FR_BEGIN;
                        frame_pos   = 9'd1;
                    end
                end
            endcase
            if (byte_results.size() > 0)
            begin
                tail      = byte_results.pop_back();
                tail.last = 1'b1;
                byte_results.push_back(tail);
            end
            foreach (byte_results[i])
            begin
                expected_results.push_back(byte_results[i]);
            end
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(fufr_pkg::result_t got);
            fufr_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual kind %0d",
                         $time, got.kind);
                $display("    reply 0x%0h addr 0x%0h data 0x%0h count %0d last %0b",
                         got.reply, got.addr, got.data, got.count, got.last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_kind", 64'(want.kind), 64'(got.kind));
            compare_field("reply_byte", 64'(want.reply), 64'(got.reply));
            compare_field("flash_address", 64'(want.addr), 64'(got.addr));
            compare_field("write_data", want.data, got.data);
            compare_field("write_byte_count", 64'(want.count), 64'(got.count));
            compare_field("last_of_run", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_wr_en     = 1'b0;
    logic [31:0]                    cfg_wr_data   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [fufr_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;

    deframer_scoreboard sb = new();

    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;

    ready_mode_t ready_mode  = RDY_ALWAYS;
    int unsigned mode_left   = 0;
    int unsigned stall_cycle = 0;

    firmware_update_frame_receiver i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: switch at random among stall patterns
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 300);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        stall_cycle <= stall_cycle + 1;
        case (ready_mode)
            RDY_ALWAYS:  m_axis_tready <= 1'b1;
            RDY_HALF:    m_axis_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= ((stall_cycle % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin : result_monitor
        fufr_pkg::result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind  = m_axis_tuser;
            got.reply = m_axis_tdata[fufr_pkg::TD_REPLY_LSB +: 8];
            got.addr  = m_axis_tdata[fufr_pkg::TD_ADDR_LSB +: fufr_pkg::ADDR_W];
            got.data  = m_axis_tdata[fufr_pkg::TD_DATA_LSB +: fufr_pkg::DATA_W];
            got.count = m_axis_tdata[fufr_pkg::TD_CNT_LSB +: fufr_pkg::CNT_W];
            got.last  = m_axis_tlast;
            sb.check_result(got);
        end
    end

    // Send one byte in bursts with random gaps; return once the transaction is taken
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        sb.note_rx_byte(value);
        bytes_sent++;
    endtask

    // Hold the sender until every expected result has arrived and the block is quiet
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_count() != 0)
        begin
            @(negedge clk);
        end
        repeat (IDLE_GUARD) @(negedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_base(value);
    endtask

    task automatic send_begin_frame(input logic [15:0] size, input logic [7:0] end_byte);
        send_byte(fufr_pkg::BYTE_BEGIN_SOF);
        send_byte(size[15:8]);
        send_byte(size[7:0]);
        send_byte(end_byte);
    endtask

    task automatic send_data_frame(input int unsigned len, input logic [7:0] end_byte);
        send_byte(fufr_pkg::BYTE_DATA_SOF);
        send_byte(len[7:0]);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        send_byte(end_byte);
    endtask

    function automatic logic [7:0] other_byte(logic [7:0] avoid);
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == avoid)
        begin
            v = ~avoid;
        end
        return v;
    endfunction

    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            return fufr_pkg::MAX_PAYLOAD;
        end
        if (roll < 14)
        begin
            return $urandom_range(fufr_pkg::MAX_PAYLOAD - 8, fufr_pkg::MAX_PAYLOAD - 1);
        end
        if (roll < 20)
        begin
            return 0;
        end
        return $urandom_range(1, 16);
    endfunction

    function automatic logic [31:0] pick_base();
        int unsigned roll;
        logic [31:0] sector;
        roll   = $urandom_range(0, 99);
        sector = $urandom & ~(fufr_pkg::SECTOR_BYTES - 1);
        // land the next frame on a sector start
        if (roll < 35)
        begin
            return sector - sb.image_offset;
        end
        // make write addresses wrap past the top of the address space
        if (roll < 50)
        begin
            return 32'hFFFF_FFF0 - sb.image_offset;
        end
        if (roll < 60)
        begin
            return 32'hFFFF_FFFF;
        end
        if (roll < 70)
        begin
            return 32'h0000_0000;
        end
        return $urandom;
    endfunction

    initial
    begin : stimulus
        int unsigned n_frames;
        int unsigned lens [4];
        int unsigned total;
        int unsigned roll;
        int unsigned image_idx;
        int unsigned random_start;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray bytes while idle are ignored
        send_byte(8'h00);
        send_byte(8'hFF);
        // empty image, then an empty data frame: erase, ack, finished
        send_begin_frame(16'h0000, fufr_pkg::BYTE_BEGIN_EOF);
        send_data_frame(0, fufr_pkg::BYTE_DATA_EOF);
        // bad begin end byte clears the size
        send_begin_frame(16'h1234, 8'hFF);
        // one full word and one single-byte word
        send_byte(fufr_pkg::BYTE_DATA_SOF);
        send_byte(8'd9);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'hFE);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h42);
        send_byte(fufr_pkg::BYTE_DATA_EOF);

        random_start = bytes_sent;
        image_idx    = 0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            if (image_idx == 0)
            begin
                write_base(32'hFFFF_FFFF);
                // payload longer than the buffer: extra bytes dropped, answered with error
                send_data_frame(fufr_pkg::MAX_PAYLOAD + 6, fufr_pkg::BYTE_DATA_EOF);
            end
            else if (image_idx == 1)
            begin
                write_base(32'h0000_0000);
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                write_base(pick_base());
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                drain_results();
            end

            n_frames = $urandom_range(1, 4);
            total    = 0;
            for (int i = 0; i < n_frames; i++)
            begin
                lens[i] = pick_length();
                total += lens[i];
            end
            roll = $urandom_range(0, 99);
            send_begin_frame(16'(sb.image_offset + total),
                             (roll < 90) ? fufr_pkg::BYTE_BEGIN_EOF :
                                           other_byte(fufr_pkg::BYTE_BEGIN_EOF));

            for (int i = 0; i < n_frames; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                    send_data_frame(lens[i], fufr_pkg::BYTE_DATA_EOF);
                end
                else if (roll < 11)
                begin
                    send_data_frame(lens[i], other_byte(fufr_pkg::BYTE_DATA_EOF));
                end
                else if (roll < 15)
                begin
                    send_data_frame($urandom_range(fufr_pkg::MAX_PAYLOAD + 1,
                                                   fufr_pkg::MAX_PAYLOAD + 12),
                                    fufr_pkg::BYTE_DATA_EOF);
                end
                else if (roll < 18)
                begin
                    // begin frame cut short, swallowing the start of the next frame
                    send_byte(fufr_pkg::BYTE_BEGIN_SOF);
                    send_byte(8'($urandom_range(0, 255)));
                    send_data_frame(lens[i], fufr_pkg::BYTE_DATA_EOF);
                end
                else
                begin
                    send_data_frame(lens[i], fufr_pkg::BYTE_DATA_EOF);
                end
            end
            image_idx++;
        end

        drain_results();
        if (sb.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
